[src/keypad_poll_autorepeat_macros.svh]
// Assertion macros for the keypad poll block.
// No dependencies; included by modules that check their own logic.
`ifndef KEYPAD_POLL_AUTOREPEAT_MACROS_SVH
`define KEYPAD_POLL_AUTOREPEAT_MACROS_SVH

`ifndef SYNTH

// Same-cycle implication, checked on clk and disabled during rst.
`define KPA_ASSERT_IMP(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("keypad_poll_autorepeat: check failed");

// Next-cycle implication, checked on clk and disabled during rst.
`define KPA_ASSERT_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("keypad_poll_autorepeat: check failed");

`else

`define KPA_ASSERT_IMP(lbl, pre, post)
`define KPA_ASSERT_NEXT(lbl, pre, post)

`endif

`endif

[src/kpa_pkg.sv]
// Types, constants and helpers for the keypad poll block.
// No dependencies.
package kpa_pkg;

  localparam int unsigned NumButtons    = 8;
  localparam int unsigned NumDirections = 4;

  localparam logic [15:0] PollGapReset        = 16'd15;
  localparam logic [15:0] RepeatDelayReset    = 16'd350;
  localparam logic [15:0] RepeatIntervalReset = 16'd80;

  typedef logic [2:0]  key_index_t;
  typedef logic [1:0]  dir_index_t;
  typedef logic [31:0] ms_t;
  typedef logic [15:0] cfg_ms_t;
  typedef logic [7:0]  cfg_addr_t;

  // Register indexes on the config channel.
  typedef enum logic [7:0] {
    REG_ENABLE          = 8'd0,
    REG_POLL_GAP        = 8'd1,
    REG_REPEAT_DELAY    = 8'd2,
    REG_REPEAT_INTERVAL = 8'd3
  } cfg_reg_t;

  typedef struct packed {
    logic       key_valid;
    key_index_t key_index;
    logic       is_repeat;
  } key_event_t;

  typedef struct packed {
    logic       hit;
    key_index_t index;
  } first_set_t;

  // Lowest set bit of an 8-bit vector.
  function automatic first_set_t first_set(input logic [NumButtons-1:0] bits);
    first_set_t res;
    res.hit   = 1'b0;
    res.index = '0;
    for (int i = NumButtons - 1; i >= 0; i--) begin
      if (bits[i]) begin
        res.hit   = 1'b1;
        res.index = key_index_t'(i);
      end
    end
    return res;
  endfunction

endpackage

[src/keypad_poll_autorepeat.sv]
// Keypad poll with auto-repeat: top level.
// Depends on kpa_pkg and keypad_poll_autorepeat_macros.svh.
//
// Usage:
//  - Poll channel (in_valid / in_stall): one transfer carries now_ms and
//    button_levels. A transfer happens at a rising edge with in_valid high
//    and in_stall low.
//  - Result channel (out_valid / out_stall): exactly one result per poll,
//    carrying key_valid, key_index and is_repeat. key_valid low means the
//    poll was gated (disabled or too soon) or found nothing to report.
//  - Config channel (cfg_valid / cfg_ready): cfg_index picks the register
//    (0 enable, 1 poll gap, 2 repeat delay, 3 repeat interval), cfg_data
//    carries the value; other indexes are dropped. cfg_ready is always high.
//    Write only while no poll is in flight.
//  - Registers: a poll passes the poll register and then the result
//    register (two register stages) before its result is presented.
//  - Throughput: one poll per cycle while out_stall is low. The per-poll
//    work is one subtract and compare for the gap, an 8-bit priority encode
//    and one add for the deadline, all between poll and result registers.
//  - Stall: while out_stall holds a result, the poll register still loads
//    once; after that in_stall rises until the result drains.
//  - Reset (rst, synchronous): pipeline empties, registers return to enable
//    0, gap 15, delay 350, interval 80, and all poll history clears.
module keypad_poll_autorepeat (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  kpa_pkg::ms_t       now_ms,
  input  logic [7:0]         button_levels,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               key_valid,
  output kpa_pkg::key_index_t key_index,
  output logic               is_repeat,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  kpa_pkg::cfg_addr_t cfg_index,
  input  kpa_pkg::cfg_ms_t   cfg_data
);
  import kpa_pkg::*;

  `include "keypad_poll_autorepeat_macros.svh"

  // Config registers
  logic    enable;
  cfg_ms_t poll_gap_ms;
  cfg_ms_t repeat_delay_ms;
  cfg_ms_t repeat_interval_ms;

  // Poll history
  ms_t                   last_poll_time;
  logic [NumButtons-1:0] previous_levels;
  logic                  repeat_armed;
  dir_index_t            repeat_button;
  ms_t                   repeat_deadline;

  // Poll register
  logic                  s1_valid;
  ms_t                   s1_now;
  logic [NumButtons-1:0] s1_levels;

  // Result register
  key_event_t out_event;

  logic in_fire;
  logic s2_free;
  logic s1_fire;

  assign cfg_ready = 1'b1;

  // Pipeline flow: result register frees when empty or taken.
  assign s2_free  = !out_valid || !out_stall;
  assign s1_fire  = s1_valid && s2_free;
  assign in_stall = s1_valid && !s2_free;
  assign in_fire  = in_valid && !in_stall;

  // Per-poll evaluation
  ms_t                   since_last;
  logic                  take;
  logic [NumButtons-1:0] fresh;
  first_set_t            press;
  logic                  press_dir;
  logic                  rep_held;
  ms_t                   to_deadline;
  logic                  rep_due;
  key_event_t            event_next;

  always_comb begin
    since_last  = s1_now - last_poll_time;
    take        = enable && (since_last >= {16'd0, poll_gap_ms});
    fresh       = s1_levels & ~previous_levels;
    press       = first_set(fresh);
    press_dir   = press.hit && (press.index < key_index_t'(NumDirections));
    rep_held    = repeat_armed && s1_levels[repeat_button];
    to_deadline = s1_now - repeat_deadline;
    rep_due     = !to_deadline[31];

    event_next = '0;
    if (take) begin
      if (press.hit) begin
        event_next.key_valid = 1'b1;
        event_next.key_index = press.index;
      end else if (rep_held && rep_due) begin
        event_next.key_valid = 1'b1;
        event_next.key_index = {1'b0, repeat_button};
        event_next.is_repeat = 1'b1;
      end
    end
  end

  // Config writes
  always_ff @(posedge clk) begin
    if (rst) begin
      enable             <= 1'b0;
      poll_gap_ms        <= PollGapReset;
      repeat_delay_ms    <= RepeatDelayReset;
      repeat_interval_ms <= RepeatIntervalReset;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_reg_t'(cfg_index))
        REG_ENABLE:          enable             <= cfg_data[0];
        REG_POLL_GAP:        poll_gap_ms        <= cfg_data;
        REG_REPEAT_DELAY:    repeat_delay_ms    <= cfg_data;
        REG_REPEAT_INTERVAL: repeat_interval_ms <= cfg_data;
        default: ;
      endcase
    end
  end

  // Poll history update
  always_ff @(posedge clk) begin
    if (rst) begin
      last_poll_time  <= '0;
      previous_levels <= '0;
      repeat_armed    <= 1'b0;
      repeat_button   <= '0;
      repeat_deadline <= '0;
    end else if (s1_fire && take) begin
      last_poll_time  <= s1_now;
      previous_levels <= s1_levels;
      if (press.hit) begin
        if (press_dir) begin
          repeat_armed    <= 1'b1;
          repeat_button   <= press.index[1:0];
          repeat_deadline <= s1_now + {16'd0, repeat_delay_ms};
        end
      end else if (!rep_held) begin
        repeat_armed <= 1'b0;
      end else if (rep_due) begin
        repeat_deadline <= s1_now + {16'd0, repeat_interval_ms};
      end
    end
  end

  // Poll register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_fire) begin
      s1_valid <= 1'b1;
    end else if (s1_fire) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_now    <= now_ms;
      s1_levels <= button_levels;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s2_free) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      out_event <= event_next;
    end
  end

  assign key_valid = out_event.key_valid;
  assign key_index = out_event.key_index;
  assign is_repeat = out_event.is_repeat;

  // Checks
  `KPA_ASSERT_IMP(a_stall_only_when_full, in_stall, s1_valid)
  `KPA_ASSERT_IMP(a_repeat_is_direction, out_valid && is_repeat, key_valid && !key_index[2])
  `KPA_ASSERT_NEXT(a_disabled_holds_state, s1_fire && !enable, $stable(last_poll_time) && $stable(previous_levels))
  `KPA_ASSERT_NEXT(a_dir_press_arms, s1_fire && take && press_dir, repeat_armed)

endmodule
